@@ hw/rtl/address_hash_set_probe_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the address hash set probe block.
// ---------------------------------------------------------------------------
`ifndef ADDRESS_HASH_SET_PROBE_MACROS_SVH
`define ADDRESS_HASH_SET_PROBE_MACROS_SVH
`ifndef SYNTHESIS
`define AHS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define AHS_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define AHS_ASSERT(label, clk, rst_n, prop)
`define AHS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/ahsp_pkg.sv @@
// ---------------------------------------------------------------------------
// ahsp_pkg
// Shared types and codes of the address hash set probe block.
// ---------------------------------------------------------------------------
package ahsp_pkg;
  localparam int unsigned OpW = 2;
  localparam int unsigned StW = 3;
  localparam int unsigned SlotOutW = 8;
  localparam int unsigned CntW = 9;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd1;
  localparam logic [OpW-1:0] OP_LOOKUP = 2'd2;

  localparam logic [StW-1:0] ST_FOUND     = 3'd0;
  localparam logic [StW-1:0] ST_INSERTED  = 3'd1;
  localparam logic [StW-1:0] ST_REMOVED   = 3'd2;
  localparam logic [StW-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [StW-1:0] ST_FULL      = 3'd4;

  localparam logic [1:0] MARK_UNUSED = 2'd0;
  localparam logic [1:0] MARK_LIVE   = 2'd1;
  localparam logic [1:0] MARK_TOMB   = 2'd2;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
endpackage

@@ hw/rtl/ahsp_front.sv @@
// ---------------------------------------------------------------------------
// ahsp_front
// Accepts requests and computes the FNV-1a hash one byte per cycle.
// ---------------------------------------------------------------------------
module ahsp_front #(
  parameter int unsigned AddrBits = 48,
  parameter int unsigned IdxW = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [ahsp_pkg::OpW-1:0] opcode_i,
  input  logic [AddrBits-1:0]      key_i,
  output logic                     q_valid_o,
  input  logic                     q_ready_i,
  output logic [ahsp_pkg::OpW-1:0] q_op_o,
  output logic [AddrBits-1:0]      q_key_o,
  output logic [IdxW-1:0]          q_home_o
);
  import ahsp_pkg::*;

  logic                busy_q, busy_d, done_q, done_d;
  logic [1:0]          byte_q, byte_d;
  logic [31:0]         hash_q, hash_d;
  logic [OpW-1:0]      op_q;
  logic [AddrBits-1:0] key_q;
  logic [7:0]          cur_byte;
  logic [31:0]         mixed;
  logic                accept;

  assign ready_o = !busy_q && !done_q;
  assign accept = valid_i && ready_o;
  assign cur_byte = key_q[{byte_q, 3'b000} +: 8];
  assign mixed = hash_q ^ {24'd0, cur_byte};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    byte_d = byte_q;
    hash_d = hash_q;
    if (accept) begin
      busy_d = 1'b1;
      byte_d = 2'd0;
      hash_d = FNV_BASIS;
    end else if (busy_q) begin
      hash_d = mixed * FNV_PRIME;
      byte_d = byte_q + 2'd1;
      if (byte_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (done_q && q_ready_i) begin
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      byte_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      byte_q <= byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    if (accept) begin
      op_q <= opcode_i;
      key_q <= key_i;
    end
  end

  assign q_valid_o = done_q;
  assign q_op_o = op_q;
  assign q_key_o = key_q;
  assign q_home_o = hash_q[IdxW-1:0];
endmodule

@@ hw/rtl/ahsp_queue.sv @@
// ---------------------------------------------------------------------------
// ahsp_queue
// Two-entry queue between the hash front and the probe engine.
// ---------------------------------------------------------------------------
module ahsp_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);
  logic [Width-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;
  assign out_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end
endmodule

@@ hw/rtl/ahsp_back.sv @@
// ---------------------------------------------------------------------------
// ahsp_back
// Probe engine: walks the table, applies the operation, holds the result.
// ---------------------------------------------------------------------------
module ahsp_back #(
  parameter int unsigned AddrBits = 48,
  parameter int unsigned Depth = 256,
  parameter int unsigned IdxW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ahsp_pkg::CntW-1:0]     load_limit_i,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  logic [ahsp_pkg::OpW-1:0]      q_op_i,
  input  logic [AddrBits-1:0]           q_key_i,
  input  logic [IdxW-1:0]               q_home_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [ahsp_pkg::StW-1:0]      status_o,
  output logic [ahsp_pkg::SlotOutW-1:0] slot_index_o,
  output logic [ahsp_pkg::CntW-1:0]     occupied_count_o
);
  import ahsp_pkg::*;

  localparam int unsigned LapW = IdxW + 1;
  localparam int unsigned UsedW = IdxW + 1;
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [AddrBits-1:0] key_mem [Depth];
  logic [1:0]          mark_mem [Depth];

  logic [2:0]          state_q, state_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [LapW-1:0]     steps_q, steps_d;
  logic                tomb_seen_q, tomb_seen_d;
  logic [IdxW-1:0]     tomb_idx_q, tomb_idx_d;
  logic [OpW-1:0]      op_q;
  logic [AddrBits-1:0] key_q;
  logic [UsedW-1:0]    used_q, used_d;
  logic [AddrBits-1:0] rd_key_q;
  logic [1:0]          rd_mark_q;
  logic [StW-1:0]      st_q, st_d;
  logic [IdxW-1:0]     slot_q, slot_d;
  logic                wr_en;
  logic [IdxW-1:0]     wr_idx;
  logic [1:0]          wr_mark;
  logic                wr_key;
  logic                lap_done;
  logic                over_limit;

  assign lap_done = steps_q == LapW'(Depth - 1);
  assign over_limit = ({1'b0, used_q} + 1'b1) > (UsedW + 1)'(load_limit_i);

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    steps_d = steps_q;
    tomb_seen_d = tomb_seen_q;
    tomb_idx_d = tomb_idx_q;
    used_d = used_q;
    st_d = st_q;
    slot_d = slot_q;
    wr_en = 1'b0;
    wr_idx = idx_q;
    wr_mark = MARK_UNUSED;
    wr_key = 1'b0;
    q_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxW'(Depth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          idx_d = q_home_i;
          steps_d = '0;
          tomb_seen_d = 1'b0;
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (rd_mark_q == MARK_LIVE && rd_key_q == key_q) begin
          state_d = S_OUT;
          slot_d = idx_q;
          if (op_q == OP_REMOVE) begin
            st_d = ST_REMOVED;
            wr_en = 1'b1;
            wr_mark = MARK_TOMB;
          end else begin
            st_d = ST_FOUND;
          end
        end else if (rd_mark_q == MARK_UNUSED || lap_done) begin
          state_d = S_OUT;
          slot_d = '0;
          if (op_q != OP_INSERT) begin
            st_d = ST_NOT_FOUND;
          end else if (tomb_seen_q || (rd_mark_q == MARK_TOMB)) begin
            st_d = ST_INSERTED;
            slot_d = tomb_seen_q ? tomb_idx_q : idx_q;
            wr_en = 1'b1;
            wr_idx = slot_d;
            wr_mark = MARK_LIVE;
            wr_key = 1'b1;
          end else if (rd_mark_q == MARK_UNUSED && !over_limit) begin
            st_d = ST_INSERTED;
            slot_d = idx_q;
            used_d = used_q + 1'b1;
            wr_en = 1'b1;
            wr_mark = MARK_LIVE;
            wr_key = 1'b1;
          end else begin
            st_d = ST_FULL;
          end
        end else begin
          if (rd_mark_q != MARK_LIVE && !tomb_seen_q) begin
            tomb_seen_d = 1'b1;
            tomb_idx_d = idx_q;
          end
          idx_d = idx_q + 1'b1;
          steps_d = steps_q + 1'b1;
          state_d = S_READ;
        end
      end
      S_OUT: if (ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q <= '0;
      steps_q <= '0;
      tomb_seen_q <= 1'b0;
      used_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      steps_q <= steps_d;
      tomb_seen_q <= tomb_seen_d;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tomb_idx_q <= tomb_idx_d;
    st_q <= st_d;
    slot_q <= slot_d;
    if (state_q == S_IDLE) begin
      op_q <= q_op_i;
      key_q <= q_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mark_mem[wr_idx] <= wr_mark;
    rd_mark_q <= mark_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_key) key_mem[wr_idx] <= key_q;
    rd_key_q <= key_mem[idx_q];
  end

  assign valid_o = state_q == S_OUT;
  assign status_o = st_q;
  assign slot_index_o = SlotOutW'(slot_q);
  assign occupied_count_o = CntW'(used_q);
endmodule

@@ hw/rtl/address_hash_set_probe.sv @@
// ---------------------------------------------------------------------------
// address_hash_set_probe
// Set of address keys in an open-addressed table with linear probing.
// ---------------------------------------------------------------------------
// Usage: requests enter on valid_i/ready_o with an opcode (find or insert,
// remove, lookup) and a key address. Each request yields exactly one result
// transfer on valid_o/ready_i carrying status, slot index and the count of
// slots ever used. The load limit register is written through cfg_we_i and
// cfg_wdata_i while the block is idle.
// Path: the front end hashes the key byte-serially with FNV-1a, the request
// and its hash are pushed into the queue, the back end takes them while idle,
// each probed slot passes a registered memory read and then an evaluation,
// and the result is held in the result register until it is transferred.
// Overlap: the front end takes no new request until it has handed the last
// one to the queue; the back end works on one request at a time and visits
// up to one full lap of TABLE_DEPTH slots. The slower of the two sets the rate.
// Reset: the back end sweeps the slot marks to unused, one slot per cycle,
// before it takes the first request from the queue. used slots
// clears to zero and load_limit returns to 192.
// If the receiver stalls, the result holds and the front keeps accepting
// until the two-entry queue fills.
`include "address_hash_set_probe_macros.svh"

module address_hash_set_probe #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ahsp_pkg::CntW-1:0]     cfg_wdata_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [ahsp_pkg::OpW-1:0]      opcode_i,
  input  logic [ADDR_BITS-1:0]          key_address_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [ahsp_pkg::StW-1:0]      status_o,
  output logic [ahsp_pkg::SlotOutW-1:0] slot_index_o,
  output logic [ahsp_pkg::CntW-1:0]     occupied_count_o
);
  import ahsp_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned QW = OpW + ADDR_BITS + IdxW;

  logic [CntW-1:0]      load_limit_q;
  logic                 f_valid, f_ready, b_valid, b_ready;
  logic [OpW-1:0]       f_op;
  logic [ADDR_BITS-1:0] f_key;
  logic [IdxW-1:0]      f_home;
  logic [QW-1:0]        q_out;

  // The load limit register; it is to be written only while the block is idle, which is left to the user to ensure.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_limit_q <= CntW'(192);
    end else if (cfg_we_i) begin
      load_limit_q <= cfg_wdata_i;
    end
  end

  ahsp_front #(.AddrBits(ADDR_BITS), .IdxW(IdxW)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .opcode_i, .key_i(key_address_i),
    .q_valid_o(f_valid), .q_ready_i(f_ready),
    .q_op_o(f_op), .q_key_o(f_key), .q_home_o(f_home)
  );

  ahsp_queue #(.Width(QW)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i({f_op, f_key, f_home}),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_data_o(q_out)
  );

  ahsp_back #(.AddrBits(ADDR_BITS), .Depth(TABLE_DEPTH), .IdxW(IdxW)) u_back (
    .clk_i, .rst_ni, .load_limit_i(load_limit_q),
    .q_valid_i(b_valid), .q_ready_o(b_ready),
    .q_op_i(q_out[QW-1 -: OpW]), .q_key_i(q_out[IdxW +: ADDR_BITS]),
    .q_home_i(q_out[IdxW-1:0]),
    .valid_o, .ready_i, .status_o, .slot_index_o, .occupied_count_o
  );

  // Results never report a slot for misses or a full table.
  `AHS_ASSERT(a_miss_slot_zero, clk_i, rst_ni,
              (valid_o && (status_o == ST_NOT_FOUND || status_o == ST_FULL))
              |-> slot_index_o == '0)
  // A stalled result keeps its status and count.
  `AHS_ASSERT(a_hold_result, clk_i, rst_ni,
              (valid_o && !ready_i) |=> ($stable(status_o) && $stable(occupied_count_o)))
  // Occupancy never exceeds the table.
  `AHS_ASSERT_NEVER(a_count_range, clk_i, rst_ni,
                    occupied_count_o > CntW'(TABLE_DEPTH))
endmodule

@@ tb/sv/tb_address_hash_set_probe.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for address_hash_set_probe
// Drives find-or-insert, remove and lookup requests on random bursts, keeps a
// behavioral copy of the probing table and checks every result field.
// ---------------------------------------------------------------------------

class set_scoreboard;
  logic [47:0] key_tab [256];
  logic [1:0]  mark_tab [256];
  int unsigned used_cnt;
  int unsigned limit;
  int unsigned errors;
  int unsigned mism;
  logic [2:0] exp_st [$];
  logic [7:0] exp_slot [$];
  logic [8:0] exp_cnt [$];

  function void clear();
    foreach (mark_tab[i]) mark_tab[i] = ahsp_pkg::MARK_UNUSED;
    foreach (key_tab[i]) key_tab[i] = '0;
    used_cnt = 0;
    limit = 192;
    errors = 0;
    mism = 0;
  endfunction

  function logic [31:0] fnv_low4(logic [47:0] key);
    logic [31:0] h;
    h = ahsp_pkg::FNV_BASIS;
    for (int b = 0; b < 4; b++) begin
      h = h ^ {24'd0, key[8*b +: 8]};
      h = h * ahsp_pkg::FNV_PRIME;
    end
    return h;
  endfunction

  // Notes one accepted request and queues the result it must produce.
  function void note_request(logic [1:0] op, logic [47:0] key);
    int unsigned idx, cand, hit;
    bit found, has_cand, tomb_seen;
    int unsigned tomb_idx;
    logic [2:0] st;
    int unsigned slot;
    idx = fnv_low4(key) % 256;
    found = 0; has_cand = 0; tomb_seen = 0; tomb_idx = 0; cand = 0; hit = 0;
    slot = 0;
    for (int n = 0; n < 256; n++) begin
      if (mark_tab[idx] == ahsp_pkg::MARK_UNUSED) begin
        has_cand = 1;
        cand = tomb_seen ? tomb_idx : idx;
        break;
      end
      if (mark_tab[idx] == ahsp_pkg::MARK_LIVE) begin
        if (key_tab[idx] == key) begin
          found = 1;
          hit = idx;
          break;
        end
      end else if (!tomb_seen) begin
        tomb_seen = 1;
        tomb_idx = idx;
      end
      idx = (idx + 1) % 256;
    end
    if (!found && !has_cand && tomb_seen) begin
      has_cand = 1;
      cand = tomb_idx;
    end
    if (op == ahsp_pkg::OP_INSERT) begin
      if (found) begin
        st = ahsp_pkg::ST_FOUND; slot = hit;
      end else if (!has_cand) begin
        st = ahsp_pkg::ST_FULL;
      end else if (mark_tab[cand] == ahsp_pkg::MARK_UNUSED && used_cnt + 1 > limit) begin
        st = ahsp_pkg::ST_FULL;
      end else begin
        if (mark_tab[cand] == ahsp_pkg::MARK_UNUSED) used_cnt++;
        mark_tab[cand] = ahsp_pkg::MARK_LIVE;
        key_tab[cand] = key;
        st = ahsp_pkg::ST_INSERTED; slot = cand;
      end
    end else if (op == ahsp_pkg::OP_REMOVE) begin
      if (found) begin
        mark_tab[hit] = ahsp_pkg::MARK_TOMB;
        st = ahsp_pkg::ST_REMOVED; slot = hit;
      end else begin
        st = ahsp_pkg::ST_NOT_FOUND;
      end
    end else begin
      // Lookup, and the unassigned fourth opcode that acts like it.
      if (found) begin
        st = ahsp_pkg::ST_FOUND; slot = hit;
      end else begin
        st = ahsp_pkg::ST_NOT_FOUND;
      end
    end
    exp_st.push_back(st);
    exp_slot.push_back(slot[7:0]);
    exp_cnt.push_back(used_cnt[8:0]);
  endfunction

  function void check_result(logic [2:0] st, logic [7:0] slot, logic [8:0] cnt);
    logic [2:0] e_st;
    logic [7:0] e_slot;
    logic [8:0] e_cnt;
    if (exp_st.size() == 0) begin
      errors++;
      if (mism++ < 10) $display("unexpected result st=%0d slot=%0d cnt=%0d", st, slot, cnt);
      return;
    end
    e_st = exp_st.pop_front();
    e_slot = exp_slot.pop_front();
    e_cnt = exp_cnt.pop_front();
    if (st !== e_st || slot !== e_slot || cnt !== e_cnt) begin
      errors++;
      if (mism++ < 10)
        $display("mismatch: exp st=%0d slot=%0d cnt=%0d, got st=%0d slot=%0d cnt=%0d",
                 e_st, e_slot, e_cnt, st, slot, cnt);
    end
  endfunction
endclass

module tb_address_hash_set_probe;
  import ahsp_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CntW-1:0]  cfg_wdata_i;
  logic             valid_i;
  logic             ready_o;
  logic [OpW-1:0]   opcode_i;
  logic [47:0]      key_address_i;
  logic             valid_o;
  logic             ready_i;
  logic [StW-1:0]   status_o;
  logic [SlotOutW-1:0] slot_index_o;
  logic [CntW-1:0]  occupied_count_o;

  set_scoreboard sb;
  // Keys that have been sent, so that random traffic hits existing entries.
  logic [47:0] known_keys [$];
  // Gap length left before the sender's current burst starts.
  int unsigned gap_left;
  int unsigned burst_left;

  address_hash_set_probe u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .valid_i         (valid_i),
    .ready_o         (ready_o),
    .opcode_i        (opcode_i),
    .key_address_i   (key_address_i),
    .valid_o         (valid_o),
    .ready_i         (ready_i),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .occupied_count_o(occupied_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Results are checked at the rising edge where a transfer happens.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && ready_i) begin
      sb.check_result(status_o, slot_index_o, occupied_count_o);
    end
  end

  // The receiver stalls on a repeating pattern, with a random mode that
  // switches between always ready, light stalls and heavy stalls.
  int unsigned stall_mode;
  int unsigned stall_phase;
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: ready_i <= 1'b1;
      1: ready_i <= (stall_phase % 5) != 3;
      default: ready_i <= (stall_phase % 7) < 3;
    endcase
  end

  // Sends one request; bursts and gaps are handled here so idle time lands
  // on every phase of the block's probe walk. Valid stays high between the
  // requests of one burst and drops when the burst ends.
  task automatic send_request(input logic [1:0] op, input logic [47:0] key);
    if (burst_left == 0) begin
      gap_left = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      repeat (gap_left) @(negedge clk_i);
    end
    burst_left--;
    valid_i <= 1'b1;
    opcode_i <= op;
    key_address_i <= key;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    sb.note_request(op, key);
    @(negedge clk_i);
    if (burst_left == 0) valid_i <= 1'b0;
  endtask

  // Ends a burst that is still open so that no stale request stays valid.
  task automatic stop_sending();
    if (burst_left != 0) begin
      valid_i <= 1'b0;
      burst_left = 0;
    end
  endtask

  // Waits until every result has arrived plus a short settle time, then
  // writes the load limit register.
  task automatic write_limit(input int unsigned value);
    stop_sending();
    while (sb.exp_st.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value[8:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.limit = value;
  endtask

  function automatic logic [47:0] pick_key();
    logic [47:0] k;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5 && known_keys.size() > 0) begin
      k = known_keys[$urandom_range(0, known_keys.size() - 1)];
    end else if (r < 7) begin
      // Small key range forces collisions among low bytes.
      k = {$urandom(), $urandom()};
      k[31:0] = $urandom_range(0, 63);
    end else begin
      k = {$urandom(), $urandom()};
    end
    return k;
  endfunction

  task automatic random_phase(input int unsigned count);
    logic [47:0] k;
    logic [1:0] op;
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      k = pick_key();
      r = $urandom_range(0, 9);
      if (r < 5) op = OP_INSERT;
      else if (r < 7) op = OP_REMOVE;
      else if (r < 9) op = OP_LOOKUP;
      else op = 2'd3;
      if (op == OP_INSERT) known_keys.push_back(k);
      send_request(op, k);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    valid_i = 1'b0;
    opcode_i = OP_INSERT;
    key_address_i = '0;
    ready_i = 1'b1;
    stall_mode = 0;
    stall_phase = 0;
    burst_left = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: key zero, extreme keys, every operation, the unassigned
    // opcode, absent keys, tombstone reuse and refusal at the load limit.
    send_request(OP_LOOKUP, 48'd0);
    send_request(OP_INSERT, 48'd0);
    send_request(OP_INSERT, 48'd0);
    send_request(OP_LOOKUP, 48'd0);
    send_request(OP_INSERT, 48'hFFFF_FFFF_FFFF);
    send_request(2'd3, 48'hFFFF_FFFF_FFFF);
    send_request(OP_REMOVE, 48'hFFFF_FFFF_FFFF);
    send_request(OP_REMOVE, 48'hFFFF_FFFF_FFFF);
    send_request(OP_LOOKUP, 48'hFFFF_FFFF_FFFF);
    // Same low four bytes, different upper bytes: same home slot.
    send_request(OP_INSERT, 48'h0001_1234_5678);
    send_request(OP_INSERT, 48'h8000_1234_5678);
    send_request(OP_REMOVE, 48'h0001_1234_5678);
    send_request(OP_INSERT, 48'hAAAA_1234_5678);
    send_request(OP_LOOKUP, 48'h8000_1234_5678);
    send_request(OP_REMOVE, 48'h5555_5555_5555);
    send_request(OP_INSERT, 48'h5555_5555_5555);

    // A limit of zero refuses any fresh slot but still allows tombstone reuse.
    write_limit(0);
    send_request(OP_INSERT, 48'h0000_DEAD_BEEF);
    send_request(OP_INSERT, 48'h0001_1234_5678);
    send_request(OP_LOOKUP, 48'h0000_DEAD_BEEF);

    write_limit(8);
    random_phase(120);

    // Full table: every slot used, so long laps and lap-without-free-slot.
    write_limit(256);
    for (int i = 0; i < 270; i++) send_request(OP_INSERT, {$urandom(), $urandom()});
    random_phase(60);

    write_limit(40);
    random_phase(80);

    stop_sending();
    while (sb.exp_st.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0 && sb.exp_st.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ahsp_pkg.sv
hw/rtl/ahsp_front.sv
hw/rtl/ahsp_queue.sv
hw/rtl/ahsp_back.sv
hw/rtl/address_hash_set_probe.sv
tb/sv/tb_address_hash_set_probe.sv
